>>> sv/obm_pkg.sv
// Package with constants and types shared by the order book matcher modules.
`timescale 1ns / 1ps
`default_nettype none
package obm_pkg;
	localparam int BOOK_DEPTH = 32;
	localparam int IDX_W = $clog2(BOOK_DEPTH);
	localparam int CNT_W = $clog2(BOOK_DEPTH + 1);
	localparam int KEY_W = 23;

	typedef struct packed {
		logic        side;
		logic        market;
		logic [15:0] dollars;
		logic [6:0]  cents;
		logic [19:0] quantity;
		logic [15:0] id;
		logic [7:0]  owner;
	} entry_t;

	typedef struct packed {
		logic        fill_valid;
		logic [15:0] maker_id;
		logic [7:0]  maker_owner;
		logic [19:0] fill_quantity;
		logic [15:0] fill_dollars;
		logic [6:0]  fill_cents;
		logic        maker_filled;
		logic        last;
		logic [1:0]  taker_state;
		logic        rested;
		logic        book_full_drop;
	} result_t;

	localparam logic [1:0] TAKER_NONE = 2'd0;
	localparam logic [1:0] TAKER_PART = 2'd1;
	localparam logic [1:0] TAKER_FULL = 2'd2;
endpackage
`default_nettype wire

>>> sv/obm_out_reg.sv
// Output register that holds one result beat until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none
module obm_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  obm_pkg::result_t      push_data,
	output logic                  busy,
	output logic                  valid,
	input  wire logic             ready,
	output obm_pkg::result_t      data
);
	import obm_pkg::*;
	logic    valid_q;
	result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

	assign busy  = valid_q && !ready;
	assign valid = valid_q;
	assign data  = data_q;
endmodule
`default_nettype wire

>>> sv/order_book_matcher.sv
// Top level of the price-time priority order book matcher.
// The order channel (valid, ready) takes one new order per beat; ready is high only while
// the block is idle, so the next order is taken after the previous one has finished.
// The fill channel (fill_out_valid, fill_out_ready) gives one beat per trade, or a single
// no-trade beat, and the final beat of an order has last set with the order's final state.
// Each pass over the book visits one entry per cycle with a shared price comparator. A trade
// adds a read state and a fill state, which may wait on the output register, and a full
// fill of a resting order adds a compaction sweep over the entries behind it.
// Ready stays low for the whole order: after the last pass, the done state settles the
// final beat and inserts the remainder, the wait state hands it over and the emit state
// returns to idle.
// Reset empties the book at once; entry storage needs no clearing pass.
// A fill beat is held until the next trade or the end of the order shows whether it is the
// final one. When the receiver stalls, the sequencer waits until the output register is
// free, so no beat is lost.
`timescale 1ns / 1ps
`default_nettype none
module order_book_matcher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid,
	output logic             ready,
	input  wire logic        side,
	input  wire logic        is_market,
	input  wire logic [15:0] price_dollars,
	input  wire logic [6:0]  price_cents,
	input  wire logic [19:0] order_quantity,
	input  wire logic [15:0] order_id,
	input  wire logic [7:0]  owner_id,
	output logic             fill_out_valid,
	input  wire logic        fill_out_ready,
	output logic             fill_valid,
	output logic [15:0]      maker_id,
	output logic [7:0]       maker_owner,
	output logic [19:0]      fill_quantity,
	output logic [15:0]      fill_dollars,
	output logic [6:0]       fill_cents,
	output logic             maker_filled,
	output logic             last,
	output logic [1:0]       taker_state,
	output logic             rested,
	output logic             book_full_drop
);
	import obm_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_SCAN  = 8'b00000010,
		ST_READ  = 8'b00000100,
		ST_FILL  = 8'b00001000,
		ST_SHIFT = 8'b00010000,
		ST_DONE  = 8'b00100000,
		ST_WAIT  = 8'b01000000,
		ST_EMIT  = 8'b10000000
	} state_t;

	state_t             state_q;
	entry_t             mem_q [BOOK_DEPTH];
	entry_t             rd_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   ptr_q;
	logic [IDX_W-1:0]   best_q;
	logic [KEY_W-1:0]   bkey_q;
	logic               found_q;
	logic               o_side_q, o_mkt_q;
	logic [15:0]        o_dol_q, o_id_q;
	logic [6:0]         o_cen_q;
	logic [19:0]        o_qty_q, rem_q;
	logic [7:0]         o_own_q;
	logic [CNT_W-1:0]   nres_q;
	logic               had_fill_q;
	result_t            res_q;
	logic               push;
	logic               out_busy;
	result_t            out_data;

	logic [KEY_W-1:0]   lim;
	logic [KEY_W-1:0]   ekey;
	logic               elig, better;
	entry_t             e;
	logic               fill_go;
	logic               rest_ok;
	result_t            fill_res;
	result_t            done_res;

	assign lim  = {o_dol_q, o_cen_q};
	assign e    = mem_q[ptr_q[IDX_W-1:0]];
	assign ekey = {e.dollars, e.cents};

	always_comb begin
		elig = (e.side != o_side_q) && !(o_mkt_q && e.market);
		if (!o_mkt_q) begin
			if (!o_side_q && ekey > lim) elig = 1'b0;
			if (o_side_q && ekey < lim) elig = 1'b0;
		end
		better = !found_q || (o_side_q ? (ekey > bkey_q) : (ekey < bkey_q));
	end

	assign fill_go = !had_fill_q || !out_busy;
	assign rest_ok = (rem_q != '0) && (count_q != CNT_W'(BOOK_DEPTH));
	assign push    = ((state_q == ST_FILL) && had_fill_q && !out_busy) ||
		((state_q == ST_WAIT) && !out_busy);

	always_comb begin
		fill_res              = '0;
		fill_res.fill_valid   = 1'b1;
		fill_res.maker_id     = rd_q.id;
		fill_res.maker_owner  = rd_q.owner;
		fill_res.fill_dollars = rd_q.dollars;
		fill_res.fill_cents   = rd_q.cents;
		if (rd_q.quantity > rem_q) begin
			fill_res.fill_quantity = rem_q;
		end else begin
			fill_res.fill_quantity = rd_q.quantity;
			fill_res.maker_filled  = 1'b1;
		end
		done_res                = had_fill_q ? res_q : '0;
		done_res.last           = 1'b1;
		done_res.taker_state    = (rem_q == '0) ? TAKER_FULL :
			(rem_q == o_qty_q) ? TAKER_NONE : TAKER_PART;
		done_res.rested         = rest_ok;
		done_res.book_full_drop = (rem_q != '0) && (count_q == CNT_W'(BOOK_DEPTH));
	end

	assign ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (valid) begin
						state_q <= (order_quantity == '0) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ptr_q == count_q) begin
						state_q <= found_q && (nres_q != CNT_W'(BOOK_DEPTH)) ? ST_READ : ST_DONE;
					end
				end
				ST_READ: state_q <= ST_FILL;
				ST_FILL: begin
					if (fill_go) begin
						if (rd_q.quantity > rem_q) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					if (ptr_q + 1'b1 >= count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= (rem_q == '0) ? ST_DONE : ST_SCAN;
					end
				end
				ST_DONE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (!out_busy) begin
						state_q <= ST_EMIT;
						if (res_q.rested) count_q <= count_q + 1'b1;
					end
				end
				ST_EMIT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				o_side_q   <= side;
				o_mkt_q    <= is_market;
				o_dol_q    <= price_dollars;
				o_cen_q    <= price_cents;
				o_qty_q    <= order_quantity;
				rem_q      <= order_quantity;
				o_id_q     <= order_id;
				o_own_q    <= owner_id;
				ptr_q      <= '0;
				found_q    <= 1'b0;
				nres_q     <= '0;
				had_fill_q <= 1'b0;
			end
			ST_SCAN: begin
				if (ptr_q != count_q) begin
					if (elig && better) begin
						found_q <= 1'b1;
						best_q  <= ptr_q[IDX_W-1:0];
						bkey_q  <= ekey;
					end
					ptr_q <= ptr_q + 1'b1;
				end
			end
			ST_READ: rd_q <= mem_q[best_q];
			ST_FILL: begin
				if (fill_go) begin
					res_q      <= fill_res;
					nres_q     <= nres_q + 1'b1;
					had_fill_q <= 1'b1;
					found_q    <= 1'b0;
					if (rd_q.quantity > rem_q) begin
						mem_q[best_q].quantity <= rd_q.quantity - rem_q;
						rem_q <= '0;
					end else begin
						rem_q <= rem_q - rd_q.quantity;
						ptr_q <= {1'b0, best_q};
					end
				end
			end
			ST_SHIFT: begin
				if (ptr_q + 1'b1 >= count_q) begin
					ptr_q <= '0;
				end else begin
					mem_q[ptr_q[IDX_W-1:0]] <= mem_q[ptr_q[IDX_W-1:0] + 1'b1];
					ptr_q <= ptr_q + 1'b1;
				end
			end
			ST_DONE: begin
				res_q <= done_res;
				if (rest_ok) begin
					mem_q[count_q[IDX_W-1:0]] <= '{side: o_side_q, market: o_mkt_q,
						dollars: o_mkt_q ? 16'd0 : o_dol_q,
						cents: o_mkt_q ? 7'd0 : o_cen_q,
						quantity: rem_q, id: o_id_q, owner: o_own_q};
				end
			end
			default: ;
		endcase
	end

	obm_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res_q),
		.busy      (out_busy),
		.valid     (fill_out_valid),
		.ready     (fill_out_ready),
		.data      (out_data)
	);

	assign fill_valid     = out_data.fill_valid;
	assign maker_id       = out_data.maker_id;
	assign maker_owner    = out_data.maker_owner;
	assign fill_quantity  = out_data.fill_quantity;
	assign fill_dollars   = out_data.fill_dollars;
	assign fill_cents     = out_data.fill_cents;
	assign maker_filled   = out_data.maker_filled;
	assign last           = out_data.last;
	assign taker_state    = out_data.taker_state;
	assign rested         = out_data.rested;
	assign book_full_drop = out_data.book_full_drop;
endmodule
`default_nettype wire

>>> test/order_book_matcher_test.sv
// Self-checking testbench for the order book matcher with a behavioral book predictor.
`timescale 1ns / 1ps
`default_nettype none
module order_book_matcher_test;
	import obm_pkg::*;

	typedef struct packed {
		logic        side;
		logic        market;
		logic [15:0] dollars;
		logic [6:0]  cents;
		logic [19:0] quantity;
		logic [15:0] id;
		logic [7:0]  owner;
	} order_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic valid = 1'b0;
	logic side = 1'b0;
	logic is_market = 1'b0;
	logic [15:0] price_dollars = '0;
	logic [6:0] price_cents = '0;
	logic [19:0] order_quantity = '0;
	logic [15:0] order_id = '0;
	logic [7:0] owner_id = '0;
	logic fill_out_ready = 1'b0;
	logic ready, fill_out_valid, fill_valid, maker_filled, last, rested, book_full_drop;
	logic [15:0] maker_id, fill_dollars;
	logic [7:0] maker_owner;
	logic [19:0] fill_quantity;
	logic [6:0] fill_cents;
	logic [1:0] taker_state;

	order_t pending_orders[$];
	result_t expected_fills[$];
	entry_t book[$];
	int error_count = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit quiet = 1'b0;

	order_book_matcher u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [22:0] key_of(logic [15:0] d, logic [6:0] c);
		return {d, c};
	endfunction

	task automatic add_fill(input result_t r);
		expected_fills.insert(expected_fills.size(), r);
	endtask

	task automatic add_order(input order_t o);
		pending_orders.insert(pending_orders.size(), o);
	endtask

	task automatic match_order(input order_t o);
		logic [19:0] remaining;
		logic [22:0] lim, k, bkey;
		int best, n;
		bit found;
		result_t r;
		entry_t e;
		remaining = o.quantity;
		lim = key_of(o.dollars, o.cents);
		n = 0;
		while (remaining != '0 && n < BOOK_DEPTH) begin
			found = 1'b0;
			best = 0;
			bkey = '0;
			for (int i = 0; i < book.size(); i++) begin
				k = key_of(book[i].dollars, book[i].cents);
				if (book[i].side == o.side) continue;
				if (o.market && book[i].market) continue;
				if (!o.market && !o.side && k > lim) continue;
				if (!o.market && o.side && k < lim) continue;
				if (!found || (o.side ? k > bkey : k < bkey)) begin
					found = 1'b1;
					best = i;
					bkey = k;
				end
			end
			if (!found) break;
			r = '0;
			r.fill_valid = 1'b1;
			r.maker_id = book[best].id;
			r.maker_owner = book[best].owner;
			r.fill_dollars = book[best].dollars;
			r.fill_cents = book[best].cents;
			if (book[best].quantity > remaining) begin
				r.fill_quantity = remaining;
				book[best].quantity -= remaining;
				remaining = '0;
			end else begin
				r.fill_quantity = book[best].quantity;
				r.maker_filled = 1'b1;
				remaining -= book[best].quantity;
				book.delete(best);
			end
			add_fill(r);
			n++;
		end
		if (n == 0) begin
			r = '0;
			add_fill(r);
		end
		r = expected_fills.pop_back();
		r.last = 1'b1;
		r.taker_state = remaining == '0 ? TAKER_FULL :
			(remaining == o.quantity ? TAKER_NONE : TAKER_PART);
		if (remaining != '0) begin
			if (book.size() < BOOK_DEPTH) begin
				e.side = o.side;
				e.market = o.market;
				e.dollars = o.market ? 16'd0 : o.dollars;
				e.cents = o.market ? 7'd0 : o.cents;
				e.quantity = remaining;
				e.id = o.id;
				e.owner = o.owner;
				book.insert(book.size(), e);
				r.rested = 1'b1;
			end else begin
				r.book_full_drop = 1'b1;
			end
		end
		add_fill(r);
	endtask

	task automatic report(input string what, input result_t got, input result_t want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic order_t make_order(int s, int m, int d, int c, int q, int id);
		order_t o;
		logic [31:0] own;
		own = $urandom;
		o.side = s[0];
		o.market = m[0];
		o.dollars = d[15:0];
		o.cents = c[6:0];
		o.quantity = q[19:0];
		o.id = id[15:0];
		o.owner = own[7:0];
		return o;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (valid && ready) begin
				match_order(pending_orders.pop_front());
			end
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
			end else if ((!valid || ready) && pending_orders.size() > 0) begin
				if (!quiet && $urandom_range(0, 5) == 0) begin
					valid <= 1'b0;
					send_gap <= $urandom_range(1, 9);
				end else begin
					valid <= 1'b1;
					{side, is_market, price_dollars, price_cents, order_quantity, order_id,
						owner_id} <= pending_orders[0];
				end
			end else if (valid && ready) begin
				valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		result_t got, want;
		if (fill_out_valid && fill_out_ready) begin
			got = {fill_valid, maker_id, maker_owner, fill_quantity, fill_dollars,
				fill_cents, maker_filled, last, taker_state, rested, book_full_drop};
			if (expected_fills.size() == 0) begin
				want = '0;
				report("unexpected beat", got, want);
			end else begin
				want = expected_fills.pop_front();
				if (got !== want) report("fill beat", got, want);
			end
		end
		if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			fill_out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			recv_gap <= $urandom_range(0, 8);
			fill_out_ready <= 1'b0;
		end else begin
			fill_out_ready <= 1'b1;
		end
	end

	initial begin
		int base;
		add_order(make_order(0, 0, 100, 0, 0, 1));
		add_order(make_order(0, 1, 0, 0, 5, 2));
		add_order(make_order(1, 1, 0, 0, 5, 3));
		add_order(make_order(1, 0, 65535, 127, 20'hFFFFF, 4));
		add_order(make_order(1, 0, 0, 0, 10, 5));
		add_order(make_order(1, 0, 10, 50, 7, 6));
		add_order(make_order(1, 0, 10, 50, 7, 6));
		add_order(make_order(0, 0, 10, 50, 30, 7));
		add_order(make_order(0, 1, 0, 0, 20'hFFFFF, 8));
		add_order(make_order(1, 0, 10, 120, 3, 9));
		add_order(make_order(0, 0, 0, 0, 2, 65535));
		for (int i = 0; i < 36; i++)
			add_order(make_order(0, 0, 1, 0, 1, 100 + i));
		add_order(make_order(1, 1, 0, 0, 50, 200));
		for (int i = 0; i < 122; i++) begin
			base = $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535) : 500;
			if ($urandom_range(0, 9) == 0)
				add_order(make_order($urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom));
			else
				add_order(make_order($urandom, $urandom_range(0, 6) == 0,
					base + $urandom_range(0, 4), $urandom_range(0, 99),
					$urandom_range(0, 30) == 0 ? $urandom : $urandom_range(0, 40),
					$urandom_range(0, 63)));
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_orders.size() < 30);
		quiet = 1'b1;
		wait (pending_orders.size() == 0 && !valid);
		wait (expected_fills.size() == 0);
		repeat (200) @(posedge clk);
		if (error_count == 0 && expected_fills.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#10000000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

>>> order_book_matcher.f
sv/obm_pkg.sv
sv/obm_out_reg.sv
sv/order_book_matcher.sv
test/order_book_matcher_test.sv
